// File: rtl/core/byte_ring_to_can_frame_packer_top_defines.svh
// Assertion macros for the byte ring to CAN frame packer.
`ifndef BYTE_RING_TO_CAN_FRAME_PACKER_TOP_DEFINES_SVH
`define BYTE_RING_TO_CAN_FRAME_PACKER_TOP_DEFINES_SVH

// clocked property, masked while reset is high
`define BRCFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked property, checked through reset as well
`define BRCFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: rtl/core/brcfp_pkg.sv
// Shared constants and types of the byte ring to CAN frame packer.
`default_nettype none

package brcfp_pkg;

   localparam int RING_DEPTH_DEF  = 1024;
   localparam int FRAME_BYTES_DEF = 8;

   localparam int ID_W       = 11;
   localparam int REQ_ID_W   = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 104;

   localparam logic [ID_W-1:0]     BOOT_RX_ID = 11'd256;
   localparam logic [ID_W-1:0]     BOOT_TX_ID = 11'd257;
   localparam logic [REQ_ID_W-1:0] ID_LIMIT   = 16'h07FF;
   localparam logic [3:0]          FRAME_LEN_MAX = 4'd8;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POLL   = 2'd1;
   localparam logic [1:0] ACT_SET_ID = 2'd2;

   localparam logic CSR_BOOT_RX = 1'b0;
   localparam logic CSR_BOOT_TX = 1'b1;

   typedef struct packed {
      logic            accepted;
      logic            frame_valid;
      logic [ID_W-1:0] frame_id;
      logic [3:0]      frame_length;
      logic [63:0]     frame_data;
      logic [ID_W-1:0] shown_receive_id;
      logic [ID_W-1:0] shown_transmit_id;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/brcfp_ring_mem.sv
// Single-port byte ring memory with registered read data.
`default_nettype none

module brcfp_ring_mem #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          mem_en,
   input  logic                          mem_we,
   input  logic [$clog2(RING_DEPTH)-1:0] mem_addr,
   input  logic [7:0]                    mem_wdata,
   output logic [7:0]                    mem_rdata
);

   logic [7:0] mem_ff [RING_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= mem_ff[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/core/brcfp_ctrl.sv
// Sequencer: ring pointers, identifier state and frame gathering.
`default_nettype none

module brcfp_ctrl #(
   parameter int RING_DEPTH  = 1024,
   parameter int FRAME_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [7:0]                         req_byte,
   input  logic [brcfp_pkg::REQ_ID_W-1:0]     req_rx_id,
   input  logic [brcfp_pkg::REQ_ID_W-1:0]     req_tx_id,
   input  logic                               req_sink,
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [brcfp_pkg::ID_W-1:0]         csr_wdata,
   input  logic                               out_free,
   output logic                               res_valid,
   output brcfp_pkg::rsp_type                 res,
   output logic                               mem_en,
   output logic                               mem_we,
   output logic [$clog2(RING_DEPTH)-1:0]      mem_addr,
   output logic [7:0]                         mem_wdata,
   input  logic [7:0]                         mem_rdata
);

   import brcfp_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_FIN} state_type;

   state_type           state_ff;
   logic [PTR_W-1:0]    wp_ff, rp_ff, cursor_ff;
   logic [PTR_W-1:0]    wp_in, cursor_in;
   logic [3:0]          issued_ff, recvd_ff;
   logic                pend_ff;
   logic [1:0]          act_ff;
   logic [7:0]          byte_ff;
   logic [REQ_ID_W-1:0] rxq_ff, txq_ff;
   logic                sink_ff;
   logic [ID_W-1:0]     act_rx_ff, act_tx_ff, wait_rx_ff, wait_tx_ff;
   logic                chg_ff;
   logic                acc_ff, fv_ff;
   logic [ID_W-1:0]     fid_ff;
   logic [3:0]          flen_ff;
   logic [63:0]         fdata_ff;
   logic                ring_full, ring_empty, id_ok, issue, do_push;

   always_comb begin
      wp_in      = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      cursor_in  = (cursor_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : cursor_ff + 1'b1;
      ring_full  = (wp_in == rp_ff);
      ring_empty = (rp_ff == wp_ff);
      id_ok      = (rxq_ff <= ID_LIMIT) && (txq_ff <= ID_LIMIT) && (rxq_ff != txq_ff);
      issue      = (state_ff == S_READ) && (cursor_ff != wp_ff)
                   && (issued_ff < 4'(FRAME_BYTES));
      do_push    = (state_ff == S_EXEC) && (act_ff == ACT_PUSH) && !ring_full;
   end

   assign mem_en    = do_push | issue;
   assign mem_we    = do_push;
   assign mem_addr  = do_push ? wp_ff : cursor_ff;
   assign mem_wdata = byte_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FIN) && out_free;

   always_comb begin
      res.accepted          = acc_ff;
      res.frame_valid       = fv_ff;
      res.frame_id          = fid_ff;
      res.frame_length      = flen_ff;
      res.frame_data        = fdata_ff;
      res.shown_receive_id  = chg_ff ? wait_rx_ff : act_rx_ff;
      res.shown_transmit_id = chg_ff ? wait_tx_ff : act_tx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
         pend_ff    <= 1'b0;
         chg_ff     <= 1'b0;
         act_rx_ff  <= BOOT_RX_ID;
         act_tx_ff  <= BOOT_TX_ID;
         wait_rx_ff <= BOOT_RX_ID;
         wait_tx_ff <= BOOT_TX_ID;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  act_ff   <= req_action;
                  byte_ff  <= req_byte;
                  rxq_ff   <= req_rx_id;
                  txq_ff   <= req_tx_id;
                  sink_ff  <= req_sink;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               acc_ff    <= 1'b0;
               fv_ff     <= 1'b0;
               fid_ff    <= '0;
               flen_ff   <= '0;
               fdata_ff  <= '0;
               issued_ff <= '0;
               recvd_ff  <= '0;
               pend_ff   <= 1'b0;
               cursor_ff <= rp_ff;
               state_ff  <= S_FIN;
               case (act_ff)
                  ACT_PUSH: begin
                     if (!ring_full) begin
                        wp_ff  <= wp_in;
                        acc_ff <= 1'b1;
                     end
                  end
                  ACT_POLL: begin
                     if (ring_empty) begin
                        if (chg_ff) begin
                           act_rx_ff <= wait_rx_ff;
                           act_tx_ff <= wait_tx_ff;
                           chg_ff    <= 1'b0;
                        end
                     end else begin
                        fv_ff    <= 1'b1;
                        fid_ff   <= act_tx_ff;
                        state_ff <= S_READ;
                     end
                  end
                  ACT_SET_ID: begin
                     if (id_ok) begin
                        wait_rx_ff <= rxq_ff[ID_W-1:0];
                        wait_tx_ff <= txq_ff[ID_W-1:0];
                        chg_ff     <= 1'b1;
                        acc_ff     <= 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_READ: begin
               pend_ff <= issue;
               if (issue) begin
                  cursor_ff <= cursor_in;
                  issued_ff <= issued_ff + 1'b1;
               end
               if (pend_ff) begin
                  fdata_ff[{recvd_ff[2:0], 3'b000} +: 8] <= mem_rdata;
                  recvd_ff <= recvd_ff + 1'b1;
               end
               if (!issue && !pend_ff) begin
                  flen_ff <= issued_ff;
                  if (sink_ff) begin
                     rp_ff <= cursor_ff;
                  end
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_we) begin
            case (csr_addr)
               CSR_BOOT_RX: begin
                  act_rx_ff  <= csr_wdata;
                  wait_rx_ff <= csr_wdata;
               end
               CSR_BOOT_TX: begin
                  act_tx_ff  <= csr_wdata;
                  wait_tx_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/brcfp_out_stage.sv
// Output register between the sequencer and the result stream.
`default_nettype none

module brcfp_out_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  brcfp_pkg::rsp_type                  res,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [brcfp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   import brcfp_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            valid_ff <= load;
         end
         if (load) begin
            data_ff <= {1'b0, res.shown_transmit_id, res.shown_receive_id,
                        res.frame_data, res.frame_length, res.frame_id,
                        res.frame_valid, res.accepted};
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/byte_ring_to_can_frame_packer_top.sv
// Top level of the byte ring to CAN frame packer.
//
// req_ stream: one word per command; req_tuser is the action (push byte, poll,
// identifier change). rsp_ stream: exactly one result word per command, in order.
// csr_ port: a write to index 0 or 1 loads the receive or transmit boot
// identifier into both the active and the pending identifier of that kind.
// Push, identifier change and empty-ring polls pass from accept through the
// execute and finish states; the result word is loaded into the output register
// from the finish state. A poll that gathers up to FRAME_BYTES bytes also passes
// through the read state: the ring is one single-port memory read one byte per cycle.
// Reset (synchronous) clears both ring pointers, the pending flag and the
// output register and loads identifiers 256/257; ring contents are left as
// they are, with no clearing pass. When rsp_tready is low the finished word
// stays in the output register; the next command is taken and worked off,
// then the block waits with its result until the register frees.
`default_nettype none

module byte_ring_to_can_frame_packer_top #(
   parameter int RING_DEPTH  = brcfp_pkg::RING_DEPTH_DEF,
   parameter int FRAME_BYTES = brcfp_pkg::FRAME_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // byte_value[7:0], new_receive_id[23:8], new_transmit_id[39:24],
   // sink_accepts[40], zero pad [47:41]
   input  logic [brcfp_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], frame_valid[1], frame_id[12:2], frame_length[16:13],
   // frame_data[80:17], shown_receive_id[91:81], shown_transmit_id[102:92],
   // zero pad [103]
   output logic [brcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [brcfp_pkg::ID_W-1:0]       csr_wdata
);

   import brcfp_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic             out_free, res_valid;
   rsp_type          res;
   logic             mem_en, mem_we;
   logic [PTR_W-1:0] mem_addr;
   logic [7:0]       mem_wdata, mem_rdata;

   brcfp_ctrl #(
      .RING_DEPTH  (RING_DEPTH),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_rx_id  (req_tdata[23:8]),
      .req_tx_id  (req_tdata[39:24]),
      .req_sink   (req_tdata[40]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .mem_en     (mem_en),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   brcfp_ring_mem #(
      .RING_DEPTH (RING_DEPTH)
   ) u_mem (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   brcfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/brcfp_checker.sv
// Port-level checks of the packer, bound to its top level.
`default_nettype none

`include "byte_ring_to_can_frame_packer_top_defines.svh"

module brcfp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [brcfp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import brcfp_pkg::*;

   `BRCFP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   `BRCFP_ASSERT(a_frame_len, clock, reset, rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[16:13] != 4'd0 && rsp_tdata[16:13] <= FRAME_LEN_MAX && !rsp_tdata[0], "offered frame with bad length or accepted flag")

   `BRCFP_ASSERT(a_no_frame_zero, clock, reset, rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[80:2] == 79'd0, "frame fields not zero without a frame")

   `BRCFP_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind byte_ring_to_can_frame_packer_top brcfp_checker u_brcfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
